### hdl/oft_pkg.sv
// shared constants, operation codes and table address helper for the opponent table engine
package oft_pkg;

  localparam int MAX_TEAMS   = 16;
  localparam int ROUND_SLOTS = MAX_TEAMS - 1;
  localparam int TABLE_DEPTH = MAX_TEAMS * ROUND_SLOTS;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int TEAM_W      = 4;
  localparam int COUNT_W     = 5;
  localparam int COST_W      = 11;
  localparam int PATH_W      = 5;

  localparam logic [COUNT_W-1:0] TEAM_COUNT_RESET = 5'd16;
  localparam logic [COUNT_W-1:0] TEAM_COUNT_MIN   = 5'd4;
  localparam logic [COUNT_W-1:0] TEAM_COUNT_MAX   = COUNT_W'(MAX_TEAMS);

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_EVAL  = 2'd1,
    OP_CHECK = 2'd2,
    OP_SWAP  = 2'd3
  } op_t;

  function automatic logic [ADDR_W-1:0] table_addr(input logic [TEAM_W-1:0] t,
                                                   input logic [TEAM_W-1:0] r);
    logic [ADDR_W-1:0] row;
    row = ADDR_W'({t, 4'b0000}) - ADDR_W'(t);
    return row + ADDR_W'(r);
  endfunction

endpackage

### hdl/one_factor_table_engine_unit.sv
// opponent table engine: load, cycle check, round swap and full table evaluation
//
// Usage: items arrive on in_valid/in_ready with operation, team, round_a, round_b
// and opponent_value; every item gives one result on out_valid/out_ready with
// cost_count, all_perfect, cycle_full and walk_error. The user must write team_count
// through cfg_write_en/cfg_write_data only while the block is idle; this is not enforced.
// The opponent table sits in one synchronous 240 x 4 memory, one read and one
// write per cycle, with a registered read. A load with round_a below 15 writes on
// the transfer edge and goes on through S_OUT to out_valid; out-of-range checks and
// swaps go to S_OUT likewise. A check walks the two-round cycle one step at a time,
// through S_MID and S_CUR (one memory read each half step). A swap walks it too,
// then exchanges the two round entries of each recorded team: read, read, write,
// write. An evaluation runs one walk per team and round pair, 1680 walks for sixteen
// teams. One item is in work at a time; in_ready is high only when idle. A finished
// result sits in the output register, so the next item is taken while it waits; a
// later result waits for that register to drain.
// Reset sets team_count to 16 and empties the output; table contents are
// undefined until loaded.
module one_factor_table_engine_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write_en,
  input  logic [oft_pkg::COUNT_W-1:0]   cfg_write_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    operation,
  input  logic [oft_pkg::TEAM_W-1:0]    team,
  input  logic [oft_pkg::TEAM_W-1:0]    round_a,
  input  logic [oft_pkg::TEAM_W-1:0]    round_b,
  input  logic [oft_pkg::TEAM_W-1:0]    opponent_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [oft_pkg::COST_W-1:0]    cost_count,
  output logic                          all_perfect,
  output logic                          cycle_full,
  output logic                          walk_error
);

  typedef enum logic [3:0] {
    S_IDLE, S_WSTART, S_MID, S_CUR, S_WEND,
    S_SW_A, S_SW_B, S_SW_WA, S_SW_WB, S_OUT
  } state_t;

  typedef enum logic [1:0] {
    WALK_FULL, WALK_SHORT, WALK_FAIL
  } walk_res_t;

  state_t                        state;
  oft_pkg::op_t                  op_q;
  walk_res_t                     w_res;
  logic [oft_pkg::COUNT_W-1:0]   team_count;
  logic [oft_pkg::COUNT_W-1:0]   n_teams;
  logic [oft_pkg::COUNT_W-1:0]   n_rounds;

  logic [oft_pkg::TEAM_W-1:0]    w_start;
  logic [oft_pkg::TEAM_W-1:0]    w_cur;
  logic [oft_pkg::TEAM_W-1:0]    w_ra;
  logic [oft_pkg::TEAM_W-1:0]    w_rb;
  logic [oft_pkg::COUNT_W-1:0]   w_cnt;
  logic [oft_pkg::COUNT_W-1:0]   cnt_next;
  logic [oft_pkg::TEAM_W-1:0]    path [oft_pkg::MAX_TEAMS];
  logic [oft_pkg::PATH_W-1:0]    p_len;
  logic [oft_pkg::PATH_W-1:0]    sidx;
  logic [oft_pkg::TEAM_W-1:0]    sw_x;
  logic [oft_pkg::TEAM_W-1:0]    va;

  logic [oft_pkg::COST_W-1:0]    res_cost;
  logic                          res_perfect;
  logic                          res_full;
  logic                          res_err;

  logic [oft_pkg::TEAM_W-1:0]    table_mem [oft_pkg::TABLE_DEPTH];
  logic [oft_pkg::TEAM_W-1:0]    rd_data;
  logic [oft_pkg::ADDR_W-1:0]    rd_addr;
  logic                          wr_en;
  logic [oft_pkg::ADDR_W-1:0]    wr_addr;
  logic [oft_pkg::TEAM_W-1:0]    wr_data;

  logic                          accept;
  logic                          rd_bad;
  logic                          req_range_bad;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  // teams in use, saturated to the supported range
  always_comb begin
    if (team_count < oft_pkg::TEAM_COUNT_MIN) begin
      n_teams = oft_pkg::TEAM_COUNT_MIN;
    end else if (team_count > oft_pkg::TEAM_COUNT_MAX) begin
      n_teams = oft_pkg::TEAM_COUNT_MAX;
    end else begin
      n_teams = team_count;
    end
  end

  assign n_rounds      = n_teams - 5'd1;
  assign rd_bad        = ({1'b0, rd_data} >= n_teams);
  assign cnt_next      = w_cnt + 5'd2;
  assign sw_x          = path[sidx[oft_pkg::TEAM_W-1:0]];
  assign req_range_bad = ({1'b0, team} >= n_teams) || ({1'b0, round_a} >= n_rounds) ||
                         ({1'b0, round_b} >= n_rounds);

  always_comb begin
    case (state)
      S_WSTART: rd_addr = oft_pkg::table_addr(w_cur, w_rb);
      S_MID:    rd_addr = oft_pkg::table_addr(rd_data, w_ra);
      S_CUR:    rd_addr = oft_pkg::table_addr(rd_data, w_rb);
      S_SW_A:   rd_addr = oft_pkg::table_addr(sw_x, w_ra);
      S_SW_B:   rd_addr = oft_pkg::table_addr(sw_x, w_rb);
      default:  rd_addr = '0;
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = oft_pkg::table_addr(team, round_a);
    wr_data = opponent_value;
    case (state)
      S_IDLE: begin
        wr_en = accept && (oft_pkg::op_t'(operation) == oft_pkg::OP_LOAD) &&
                ({1'b0, round_a} < oft_pkg::COUNT_W'(oft_pkg::ROUND_SLOTS));
      end
      S_SW_WA: begin
        wr_en   = 1'b1;
        wr_addr = oft_pkg::table_addr(sw_x, w_ra);
        wr_data = rd_data;
      end
      S_SW_WB: begin
        wr_en   = 1'b1;
        wr_addr = oft_pkg::table_addr(sw_x, w_rb);
        wr_data = va;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // opponent table
  always_ff @(posedge clk) begin
    if (wr_en) begin
      table_mem[wr_addr] <= wr_data;
    end
    rd_data <= table_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      team_count <= oft_pkg::TEAM_COUNT_RESET;
    end else begin
      if (cfg_write_en) begin
        team_count <= cfg_write_data;
      end
      if (out_valid && out_ready && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            op_q     <= oft_pkg::op_t'(operation);
            res_cost <= '0;
            res_full <= 1'b0;
            case (oft_pkg::op_t'(operation))
              oft_pkg::OP_LOAD: begin
                res_perfect <= 1'b0;
                res_err     <= 1'b0;
                state       <= S_OUT;
              end
              oft_pkg::OP_EVAL: begin
                res_perfect <= 1'b1;
                res_err     <= 1'b0;
                w_start     <= '0;
                w_cur       <= '0;
                w_ra        <= '0;
                w_rb        <= 4'd1;
                state       <= S_WSTART;
              end
              default: begin
                res_perfect <= 1'b0;
                res_err     <= req_range_bad;
                if (req_range_bad) begin
                  state   <= S_OUT;
                end else begin
                  w_start <= team;
                  w_cur   <= team;
                  w_ra    <= round_a;
                  w_rb    <= round_b;
                  state   <= S_WSTART;
                end
              end
            endcase
          end
        end
        S_WSTART: begin
          w_cnt <= '0;
          p_len <= '0;
          state <= S_MID;
        end
        S_MID: begin
          if (rd_bad) begin
            w_res <= WALK_FAIL;
            state <= S_WEND;
          end else begin
            path[p_len[oft_pkg::TEAM_W-1:0]] <= rd_data;
            p_len <= p_len + 5'd1;
            state <= S_CUR;
          end
        end
        S_CUR: begin
          if (rd_bad) begin
            w_res <= WALK_FAIL;
            state <= S_WEND;
          end else begin
            path[p_len[oft_pkg::TEAM_W-1:0]] <= rd_data;
            p_len <= p_len + 5'd1;
            w_cnt <= cnt_next;
            if (rd_data == w_start) begin
              w_res <= (cnt_next == n_teams) ? WALK_FULL : WALK_SHORT;
              state <= S_WEND;
            end else if (cnt_next < n_teams) begin
              w_cur <= rd_data;
              state <= S_MID;
            end else begin
              w_res <= WALK_FAIL;
              state <= S_WEND;
            end
          end
        end
        S_WEND: begin
          case (op_q)
            oft_pkg::OP_EVAL: begin
              if (w_res == WALK_FULL) begin
                res_cost <= res_cost + 11'd1;
              end else begin
                res_perfect <= 1'b0;
                if (w_res == WALK_FAIL) begin
                  res_err <= 1'b1;
                end
              end
              // next team and round pair
              if (({1'b0, w_rb} + 5'd1) < n_rounds) begin
                w_cur <= w_start;
                w_rb  <= w_rb + 4'd1;
                state <= S_WSTART;
              end else if (({1'b0, w_ra} + 5'd2) < n_rounds) begin
                w_cur <= w_start;
                w_ra  <= w_ra + 4'd1;
                w_rb  <= w_ra + 4'd2;
                state <= S_WSTART;
              end else if (({1'b0, w_start} + 5'd1) < n_teams) begin
                w_start <= w_start + 4'd1;
                w_cur   <= w_start + 4'd1;
                w_ra    <= '0;
                w_rb    <= 4'd1;
                state   <= S_WSTART;
              end else begin
                state <= S_OUT;
              end
            end
            oft_pkg::OP_SWAP: begin
              if (w_res == WALK_FAIL) begin
                res_err <= 1'b1;
                state   <= S_OUT;
              end else begin
                res_full <= (w_res == WALK_FULL);
                sidx     <= '0;
                state    <= S_SW_A;
              end
            end
            oft_pkg::OP_CHECK: begin
              res_err  <= (w_res == WALK_FAIL);
              res_full <= (w_res == WALK_FULL);
              state    <= S_OUT;
            end
            default: begin
              state <= S_OUT;
            end
          endcase
        end
        S_SW_A: begin
          state <= S_SW_B;
        end
        S_SW_B: begin
          va    <= rd_data;
          state <= S_SW_WA;
        end
        S_SW_WA: begin
          state <= S_SW_WB;
        end
        S_SW_WB: begin
          if ((sidx + 5'd1) == p_len) begin
            state <= S_OUT;
          end else begin
            sidx  <= sidx + 5'd1;
            state <= S_SW_A;
          end
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            cost_count  <= res_cost;
            all_perfect <= res_perfect;
            cycle_full  <= res_full;
            walk_error  <= res_err;
            out_valid   <= 1'b1;
            state       <= S_IDLE;
          end else begin
            out_valid   <= 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
